[hdl/dsddi_pkg.sv]
package dsddi_pkg;

    // default sizing of the frame store
    localparam int DEF_MAX_BLOCK    = 4096;
    localparam int DEF_MAX_CHANNELS = 2;

    // configuration register values after reset
    localparam int RST_BLOCK_BYTES  = 4096;

    // configuration register indexes
    localparam logic [0:0] CFG_CHANNEL_COUNT = 1'd0;
    localparam logic [0:0] CFG_BLOCK_BYTES   = 1'd1;

    localparam int CFG_DATA_W = 13;

    // result status codes
    typedef enum logic [1:0] {
        ST_BYTE    = 2'd0,
        ST_DONE    = 2'd1,
        ST_PARTIAL = 2'd2
    } status_t;

    // msb-first to lsb-first by nibble, pair and bit swaps
    function automatic logic [7:0] bit_reverse(input logic [7:0] b);
        logic [7:0] t0;
        logic [7:0] t1;
        logic [7:0] t2;
        t0 = ((b  & 8'hF0) >> 4) | ((b  & 8'h0F) << 4);
        t1 = ((t0 & 8'hCC) >> 2) | ((t0 & 8'h33) << 2);
        t2 = ((t1 & 8'hAA) >> 1) | ((t1 & 8'h55) << 1);
        return t2;
    endfunction

endpackage

[hdl/dsd_frame_deinterleave_bitrev.sv]
// DSD frame de-interleaver with bit reversal. Round-robin interleaved DSD
// bytes come in one per transaction (tuser = 0); every (number of channels) *
// block_bytes of them form a frame, written into one bank of a two-bank
// frame store. A complete frame becomes pending and the banks swap; each
// later input transaction, data or drain (tuser = 1), then emits one byte of
// the pending frame, bit-reversed to lsb-first, in per-channel block order:
// all of channel 0's block, then channel 1's. A drain with nothing pending
// returns status 1 (done) or 2 (partial frame, which is discarded). The
// block takes one input transaction per clock for as long as the output
// side accepts; the result path has two register levels (store read data
// with its stage flags, then the output register), so a result passes
// through both, in that order, before it shows on the output. The store has
// one write port (fill bank) and one read port (pending bank); the two
// always address opposite banks, so no forwarding is needed. Configuration
// writes are accepted at any time but belong in idle periods; a pending
// frame keeps draining with the new sizes. Registers: index 0 number of
// channels (0 acts as 1, 3 as 2), index 1 block_bytes (0 acts as 1, above
// MAX_BLOCK acts as MAX_BLOCK).
module dsd_frame_deinterleave_bitrev
    import dsddi_pkg::*;
#(
    parameter int MAX_BLOCK    = DEF_MAX_BLOCK,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] data_byte
    input  logic [0:0]            s_tuser,   // [0] mode (1 = drain)

    // output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [7:0] out_byte
    output logic                  m_tlast,   // last_of_frame
    output logic [3:0]            m_tuser,   // [0] channel, [1] last_of_block,
                                             // [3:2] status

    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [0:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int BANK_SIZE = MAX_CHANNELS * MAX_BLOCK;
    localparam int BANK_AW   = (BANK_SIZE > 1) ? $clog2(BANK_SIZE) : 1;
    localparam int CNT_W     = $clog2(BANK_SIZE + 1);
    localparam int BLK_W     = $clog2(MAX_BLOCK + 1);
    localparam int POS_W     = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int MEM_DEPTH = 2 ** (BANK_AW + 1);
    localparam int BLK_RST   = (RST_BLOCK_BYTES < MAX_BLOCK) ? RST_BLOCK_BYTES : MAX_BLOCK;
    localparam logic STEREO_OK = (MAX_CHANNELS == 2);

    // effective block size of a raw register value
    function automatic logic [BLK_W-1:0] eff_block(input logic [CFG_DATA_W-1:0] v);
        logic [BLK_W-1:0] r;
        if (v == '0)
            r = BLK_W'(1);
        else if (32'(v) > 32'(MAX_BLOCK))
            r = BLK_W'(MAX_BLOCK);
        else
            r = BLK_W'(v);
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] frame_size(input logic nch2,
                                                     input logic [BLK_W-1:0] blk);
        logic [CNT_W-1:0] r;
        r = nch2 ? (CNT_W'(blk) << 1) : CNT_W'(blk);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // configuration, held in effective form
    // ---------------------------------------------------------------
    logic             nch2_reg, nch2_next;
    logic [BLK_W-1:0] blk_reg, blk_next;
    logic [CNT_W-1:0] fb_reg, fb_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        nch2_next = nch2_reg;
        blk_next  = blk_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CHANNEL_COUNT: nch2_next = STEREO_OK && (cfg_data[1:0] >= 2'd2);
                CFG_BLOCK_BYTES:   blk_next  = eff_block(cfg_data);
                default:           nch2_next = nch2_reg;
            endcase
        end
        fb_next = frame_size(nch2_next, blk_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nch2_reg <= STEREO_OK;
            blk_reg  <= BLK_W'(BLK_RST);
            fb_reg   <= frame_size(STEREO_OK, BLK_W'(BLK_RST));
        end
        else
        begin
            nch2_reg <= nch2_next;
            blk_reg  <= blk_next;
            fb_reg   <= fb_next;
        end
    end

    // ---------------------------------------------------------------
    // pipeline handshake: state/read stage, read data stage, output reg
    // ---------------------------------------------------------------
    logic    s1_valid_reg;
    logic    s1_chan_reg;
    logic    s1_lastb_reg;
    logic    s1_lastf_reg;
    status_t s1_status_reg;
    logic [7:0] rd_data_reg;

    logic    out_valid_reg;
    logic [7:0] out_byte_reg;
    logic    out_chan_reg;
    logic    out_lastb_reg;
    logic    out_lastf_reg;
    status_t out_status_reg;

    logic out_take;
    logic s1_free;
    logic accept;
    logic mode;

    assign out_take = !out_valid_reg || m_tready;
    assign s1_free  = !s1_valid_reg || out_take;
    assign s_tready = s1_free;
    assign accept   = s_tvalid && s_tready;
    assign mode     = s_tuser[0];

    // ---------------------------------------------------------------
    // frame state
    // ---------------------------------------------------------------
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             bank_reg, bank_next;
    logic [CNT_W-1:0] drain_reg, drain_next;
    logic             pend_reg, pend_next;

    logic               emit;
    logic               chan;
    logic [CNT_W-1:0]   d_sub;
    logic [POS_W-1:0]   pos;
    logic [BANK_AW-1:0] src;
    logic [BANK_AW:0]   rd_addr;
    logic [BANK_AW:0]   wr_addr;
    logic               lastb;
    logic               lastf;
    logic [CNT_W-1:0]   d_inc;
    logic [CNT_W-1:0]   fill_inc;
    logic               has_result;
    status_t            status;

    always_comb
    begin
        // a pending frame whose index ran past a shrunk frame is finished
        emit  = pend_reg && (drain_reg < fb_reg);
        // at most two channels, so the block split is one compare-subtract
        chan  = (drain_reg >= CNT_W'(blk_reg));
        d_sub = chan ? (drain_reg - CNT_W'(blk_reg)) : drain_reg;
        pos   = POS_W'(d_sub);
        src   = nch2_reg ? BANK_AW'({pos, chan}) : BANK_AW'(pos);
        rd_addr = {~bank_reg, src};
        wr_addr = {bank_reg, fill_reg[BANK_AW-1:0]};
        lastb = (d_sub == CNT_W'(blk_reg) - CNT_W'(1));
        lastf = (drain_reg == fb_reg - CNT_W'(1));
        d_inc    = drain_reg + CNT_W'(1);
        fill_inc = fill_reg + CNT_W'(1);

        has_result = emit || mode;
        if (emit)
            status = ST_BYTE;
        else if (fill_reg != '0)
            status = ST_PARTIAL;
        else
            status = ST_DONE;

        pend_next  = pend_reg;
        drain_next = drain_reg;
        fill_next  = fill_reg;
        bank_next  = bank_reg;
        if (accept)
        begin
            if (!emit)
            begin
                pend_next  = 1'b0;
                drain_next = '0;
                if (mode)
                    fill_next = '0;
            end
            else if (d_inc >= fb_reg)
            begin
                pend_next  = 1'b0;
                drain_next = '0;
            end
            else
            begin
                drain_next = d_inc;
            end

            if (!mode)
            begin
                // fill count stays below the bank size, so every byte lands
                if (fill_inc >= fb_reg)
                begin
                    bank_next  = ~bank_reg;
                    pend_next  = 1'b1;
                    drain_next = '0;
                    fill_next  = '0;
                end
                else
                begin
                    fill_next = fill_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            bank_reg  <= 1'b0;
            drain_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            fill_reg  <= fill_next;
            bank_reg  <= bank_next;
            drain_reg <= drain_next;
            pend_reg  <= pend_next;
        end
    end

    // ---------------------------------------------------------------
    // frame store: two banks, one write port, one registered read port
    // ---------------------------------------------------------------
    logic [7:0] frame_mem [MEM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (accept && !mode)
            frame_mem[wr_addr] <= s_tdata;
        if (accept && emit)
            rd_data_reg <= frame_mem[rd_addr];
    end

    // ---------------------------------------------------------------
    // read data stage
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_free)
            s1_valid_reg <= accept && has_result;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_chan_reg   <= emit && chan;
            s1_lastb_reg  <= emit && lastb;
            s1_lastf_reg  <= emit && lastf;
            s1_status_reg <= status;
        end
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_take)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_take && s1_valid_reg)
        begin
            out_byte_reg   <= (s1_status_reg == ST_BYTE) ? bit_reverse(rd_data_reg) : 8'd0;
            out_chan_reg   <= s1_chan_reg;
            out_lastb_reg  <= s1_lastb_reg;
            out_lastf_reg  <= s1_lastf_reg;
            out_status_reg <= s1_status_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_lastf_reg;
    assign m_tuser  = {out_status_reg, out_lastb_reg, out_chan_reg};

endmodule
